// ===== hw/rtl/ccr_pkg.sv =====
// Cluster chain resizer package: shared status codes, controller states and
// the command / status bundles that pass between controller and datapath.
// No dependencies.
package ccr_pkg;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_START = 2'd1,
        ST_BROKEN    = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    // Controller states
    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_DECIDE,
        S_MEAS_RD,
        S_MEAS_CHK,
        S_GROW_TEST,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_LINK,
        S_TRIM_TEST,
        S_TRIM_RD,
        S_TRIM_CHK,
        S_TAIL_RD,
        S_TAIL_CHK,
        S_REL_RD,
        S_REL_CHK,
        S_DONE
    } ccr_state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic    clr_step;      // write one free entry of the clearing pass
        logic    load;          // take the request fields
        logic    set_status_en;
        status_t status_code;
        logic    zero_start;    // result start becomes empty
        logic    rd_cur;        // read entry at the walk pointer
        logic    rd_scan;       // read entry at the free-scan pointer
        logic    meas_step;     // follow link while measuring
        logic    meas_end;      // tail found
        logic    scan_next;     // entry in use, move scan on
        logic    grab;          // mark scanned entry as end of chain
        logic    link;          // link new cluster from the old tail
        logic    trim_init;     // restart walk at the head for trimming
        logic    trim_step;     // follow link while trimming
        logic    tail_cut;      // mark kept cluster as end, move to the cut-off rest
        logic    rel_free;      // free entry at the walk pointer
        logic    rel_ok;        // release finished cleanly
        logic    out_load;      // load the result register
    } ccr_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic clr_last;
        logic bad_start;
        logic want_zero;
        logic start_zero;
        logic len_lt_want;
        logic len_gt_want;
        logic len_at_max;
        logic cnt_lt_want;
        logic scan_valid;
        logic rd_free;
        logic rd_end;
        logic rd_link_valid;
        logic out_free;
    } ccr_sts_t;

endpackage

// ===== hw/rtl/cluster_chain_resizer_top.sv =====
// Cluster chain resizer top level: controller plus datapath.
// Depends on ccr_pkg, ccr_ctrl and ccr_datapath.
//
// Usage:
//  - Request channel (in_valid / in_ready) carries chain_start and
//    wanted_clusters; result channel (out_valid / out_ready) carries
//    new_chain_start and status. One result per request.
//  - cfg_write_en / cfg_write_data write clusters_in_use; write only while
//    no request is in flight.
//  - After reset the link table is swept to all free, one entry per cycle;
//    in_ready stays low during the sweep.
//  - One request at a time through the table, which has one read and one write
//    port. Beside accepting and decoding the request and delivering the
//    result, a request reads links while measuring or freeing the chain,
//    probes entries with the first-fit scan and links each new cluster
//    after a length test while growing, and follows links while cutting
//    back before it marks the new end.
//  - A finished result sits in an output register; the next request is
//    taken while it waits and only completes once the receiver takes it.
module cluster_chain_resizer_top
    import ccr_pkg::*;
#(
    parameter int TABLE_DEPTH = 4096
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write_en,
    input  logic [11:0] cfg_write_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [27:0] chain_start,
    input  logic [11:0] wanted_clusters,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [11:0] new_chain_start,
    output logic [1:0]  status
);

    ccr_cmd_t cmd;
    ccr_sts_t sts;

    // sequencer
    ccr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // table, pointers and result register
    ccr_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write_en    (cfg_write_en),
        .cfg_write_data  (cfg_write_data),
        .chain_start     (chain_start),
        .wanted_clusters (wanted_clusters),
        .out_ready       (out_ready),
        .out_valid       (out_valid),
        .new_chain_start (new_chain_start),
        .status          (status),
        .cmd             (cmd),
        .sts             (sts)
    );

endmodule

// ===== hw/rtl/ccr_datapath.sv =====
// Cluster chain resizer datapath: link table memory, walk and scan pointers,
// counters, configuration register and result register.
// Depends on ccr_pkg.
module ccr_datapath
    import ccr_pkg::*;
#(
    parameter int TABLE_DEPTH = 4096
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write_en,
    input  logic [11:0] cfg_write_data,
    input  logic [27:0] chain_start,
    input  logic [11:0] wanted_clusters,
    input  logic        out_ready,
    output logic        out_valid,
    output logic [11:0] new_chain_start,
    output logic [1:0]  status,
    input  ccr_cmd_t    cmd,
    output ccr_sts_t    sts
);

    localparam int IW = $clog2(TABLE_DEPTH);
    localparam int SW = IW + 1;
    // entry format: end flag above the next-cluster index; all zero is free
    localparam logic [IW:0] END_ENTRY = {1'b1, {IW{1'b0}}};

    // cluster number check against the configured data area and table size
    function automatic logic clus_ok(input logic [31:0] c, input logic [11:0] ciu);
        return (c >= 32'd2) && (c <= (32'(ciu) + 32'd1)) && (c < 32'(TABLE_DEPTH));
    endfunction

    logic [IW:0]   link_mem [TABLE_DEPTH];
    logic [IW:0]   rdata_reg;

    logic [11:0]   ciu_reg,   ciu_next;
    logic [IW-1:0] clr_reg,   clr_next;
    logic          out_valid_reg, out_valid_next;

    logic [IW-1:0] start_reg, start_next;
    logic [11:0]   want_reg,  want_next;
    logic [11:0]   len_reg,   len_next;
    logic [11:0]   cnt_reg,   cnt_next;
    logic [IW-1:0] cur_reg,   cur_next;
    logic [IW-1:0] last_reg,  last_next;
    logic [IW-1:0] new_reg,   new_next;
    logic [SW-1:0] scan_reg,  scan_next;
    logic          bad_reg,   bad_next;
    status_t       status_reg, status_next;
    logic [11:0]   out_start_reg, out_start_next;
    status_t       out_status_reg, out_status_next;

    logic          wr_en;
    logic [IW-1:0] wr_addr;
    logic [IW:0]   wr_data;
    logic          rd_en;
    logic [IW-1:0] rd_addr;
    logic [IW-1:0] rd_idx;
    logic          rd_end;

    assign rd_idx = rdata_reg[IW-1:0];
    assign rd_end = rdata_reg[IW];

    // memory write port selection
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = cur_reg;
        wr_data = '0;
        priority if (cmd.clr_step)
        begin
            wr_en   = 1'b1;
            wr_addr = clr_reg;
        end
        else if (cmd.grab)
        begin
            wr_en   = 1'b1;
            wr_addr = scan_reg[IW-1:0];
            wr_data = END_ENTRY;
        end
        else if (cmd.link && (len_reg != 12'd0))
        begin
            wr_en   = 1'b1;
            wr_addr = last_reg;
            wr_data = {1'b0, new_reg};
        end
        else if (cmd.tail_cut)
        begin
            wr_en   = 1'b1;
            wr_data = END_ENTRY;
        end
        else if (cmd.rel_free)
        begin
            wr_en   = 1'b1;
        end
    end

    // memory read port selection
    assign rd_en   = cmd.rd_cur | cmd.rd_scan;
    assign rd_addr = cmd.rd_scan ? scan_reg[IW-1:0] : cur_reg;

    // link table, registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            link_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rdata_reg <= link_mem[rd_addr];
        end
    end

    // next values of the working registers
    always_comb
    begin
        ciu_next        = cfg_write_en ? cfg_write_data : ciu_reg;
        clr_next        = cmd.clr_step ? (clr_reg + IW'(1)) : clr_reg;
        out_valid_next  = cmd.out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

        start_next      = start_reg;
        want_next       = want_reg;
        len_next        = len_reg;
        cnt_next        = cnt_reg;
        cur_next        = cur_reg;
        last_next       = last_reg;
        new_next        = new_reg;
        scan_next       = scan_reg;
        bad_next        = bad_reg;
        status_next     = status_reg;
        out_start_next  = out_start_reg;
        out_status_next = out_status_reg;

        if (cmd.load)
        begin
            start_next  = chain_start[IW-1:0];
            cur_next    = chain_start[IW-1:0];
            want_next   = wanted_clusters;
            len_next    = (chain_start == 28'd0) ? 12'd0 : 12'd1;
            scan_next   = SW'(2);
            bad_next    = (chain_start != 28'd0) && !clus_ok(32'(chain_start), ciu_reg);
            status_next = ST_OK;
        end
        if (cmd.set_status_en)
        begin
            status_next = cmd.status_code;
        end
        if (cmd.zero_start || (cmd.rel_ok && (want_reg == 12'd0)))
        begin
            start_next = '0;
        end
        // measuring walk
        if (cmd.meas_step)
        begin
            cur_next = rd_idx;
            len_next = len_reg + 12'd1;
        end
        if (cmd.meas_end)
        begin
            last_next = cur_reg;
        end
        // first-fit scan and growth
        if (cmd.scan_next)
        begin
            scan_next = scan_reg + SW'(1);
        end
        if (cmd.grab)
        begin
            new_next  = scan_reg[IW-1:0];
            scan_next = scan_reg + SW'(1);
        end
        if (cmd.link)
        begin
            last_next = new_reg;
            len_next  = len_reg + 12'd1;
            if (len_reg == 12'd0)
            begin
                start_next = new_reg;
            end
        end
        // trimming and release walks
        if (cmd.trim_init)
        begin
            cur_next = start_reg;
            cnt_next = 12'd1;
        end
        if (cmd.trim_step)
        begin
            cur_next = rd_idx;
            cnt_next = cnt_reg + 12'd1;
        end
        if (cmd.tail_cut || cmd.rel_free)
        begin
            cur_next = rd_idx;
        end
        // result register
        if (cmd.out_load)
        begin
            out_start_next  = 12'(start_reg);
            out_status_next = status_reg;
        end
    end

    // control and configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ciu_reg       <= 12'd4094;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            ciu_reg       <= ciu_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        start_reg      <= start_next;
        want_reg       <= want_next;
        len_reg        <= len_next;
        cnt_reg        <= cnt_next;
        cur_reg        <= cur_next;
        last_reg       <= last_next;
        new_reg        <= new_next;
        scan_reg       <= scan_next;
        bad_reg        <= bad_next;
        status_reg     <= status_next;
        out_start_reg  <= out_start_next;
        out_status_reg <= out_status_next;
    end

    // status towards the controller
    always_comb
    begin
        sts.clr_last      = (clr_reg == IW'(TABLE_DEPTH - 1));
        sts.bad_start     = bad_reg;
        sts.want_zero     = (want_reg == 12'd0);
        sts.start_zero    = (start_reg == '0);
        sts.len_lt_want   = (len_reg < want_reg);
        sts.len_gt_want   = (len_reg > want_reg);
        sts.len_at_max    = (len_reg >= ciu_reg);
        sts.cnt_lt_want   = (cnt_reg < want_reg);
        sts.scan_valid    = clus_ok(32'(scan_reg), ciu_reg);
        sts.rd_free       = (rdata_reg == '0);
        sts.rd_end        = rd_end;
        sts.rd_link_valid = !rd_end && clus_ok(32'(rd_idx), ciu_reg);
        sts.out_free      = !out_valid_reg || out_ready;
    end

    assign out_valid       = out_valid_reg;
    assign new_chain_start = out_start_reg;
    assign status          = out_status_reg;

    // entries 0 and 1 are never data clusters: only the clearing pass writes them
    a_no_low_write: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en && !cmd.clr_step) |-> (32'(wr_addr) >= 32'd2))
        else $error("link table write to a reserved entry");

    // a new cluster is only linked while the chain is still short
    a_link_short: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.link |-> (len_reg < want_reg))
        else $error("cluster linked beyond wanted length");

    // the old tail never links to itself
    a_link_self: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.link && (len_reg != 12'd0)) |-> (last_reg != new_reg))
        else $error("tail linked to itself");

endmodule

// ===== hw/rtl/ccr_ctrl.sv =====
// Cluster chain resizer controller: sequences the clearing pass and the
// measure, grow, trim and release walks of one request.
// Depends on ccr_pkg.
module ccr_ctrl
    import ccr_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  ccr_sts_t sts,
    output ccr_cmd_t cmd
);

    ccr_state_t state_reg, state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:     if (sts.clr_last) state_next = S_IDLE;
            S_IDLE:      if (in_valid) state_next = S_DECIDE;
            S_DECIDE:
            begin
                priority if (sts.bad_start)  state_next = S_DONE;
                else if (sts.want_zero)      state_next = sts.start_zero ? S_DONE : S_REL_RD;
                else if (sts.start_zero)     state_next = S_GROW_TEST;
                else                         state_next = S_MEAS_RD;
            end
            S_MEAS_RD:   state_next = S_MEAS_CHK;
            S_MEAS_CHK:
            begin
                priority if (sts.rd_end)                          state_next = S_GROW_TEST;
                else if (!sts.rd_link_valid || sts.len_at_max)    state_next = S_DONE;
                else                                              state_next = S_MEAS_RD;
            end
            S_GROW_TEST:
            begin
                priority if (sts.len_lt_want) state_next = S_SCAN_RD;
                else if (sts.len_gt_want)     state_next = S_TRIM_TEST;
                else                          state_next = S_DONE;
            end
            S_SCAN_RD:   state_next = sts.scan_valid ? S_SCAN_CHK : S_DONE;
            S_SCAN_CHK:  state_next = sts.rd_free ? S_LINK : S_SCAN_RD;
            S_LINK:      state_next = S_GROW_TEST;
            S_TRIM_TEST: state_next = sts.cnt_lt_want ? S_TRIM_RD : S_TAIL_RD;
            S_TRIM_RD:   state_next = S_TRIM_CHK;
            S_TRIM_CHK:  state_next = sts.rd_link_valid ? S_TRIM_TEST : S_DONE;
            S_TAIL_RD:   state_next = S_TAIL_CHK;
            S_TAIL_CHK:  state_next = sts.rd_link_valid ? S_REL_RD : S_DONE;
            S_REL_RD:    state_next = S_REL_CHK;
            S_REL_CHK:
            begin
                priority if (sts.rd_end)      state_next = S_DONE;
                else if (sts.rd_link_valid)   state_next = S_REL_RD;
                else                          state_next = S_DONE;
            end
            S_DONE:      if (sts.out_free) state_next = S_IDLE;
            default:     state_next = S_CLEAR;
        endcase
    end

    // commands
    always_comb
    begin
        cmd             = '0;
        cmd.status_code = ST_OK;
        in_ready        = 1'b0;
        unique case (state_reg)
            S_CLEAR:     cmd.clr_step = 1'b1;
            S_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            S_DECIDE:
            begin
                if (sts.bad_start)
                begin
                    cmd.set_status_en = 1'b1;
                    cmd.status_code   = ST_BAD_START;
                    cmd.zero_start    = 1'b1;
                end
            end
            S_MEAS_RD:   cmd.rd_cur = 1'b1;
            S_MEAS_CHK:
            begin
                priority if (sts.rd_end)
                begin
                    cmd.meas_end = 1'b1;
                end
                else if (!sts.rd_link_valid || sts.len_at_max)
                begin
                    cmd.set_status_en = 1'b1;
                    cmd.status_code   = ST_BROKEN;
                end
                else
                begin
                    cmd.meas_step = 1'b1;
                end
            end
            S_GROW_TEST: cmd.trim_init = !sts.len_lt_want && sts.len_gt_want;
            S_SCAN_RD:
            begin
                if (sts.scan_valid)
                begin
                    cmd.rd_scan = 1'b1;
                end
                else
                begin
                    cmd.set_status_en = 1'b1;
                    cmd.status_code   = ST_FULL;
                end
            end
            S_SCAN_CHK:
            begin
                cmd.grab      = sts.rd_free;
                cmd.scan_next = !sts.rd_free;
            end
            S_LINK:      cmd.link = 1'b1;
            S_TRIM_TEST: ;
            S_TRIM_RD:   cmd.rd_cur = 1'b1;
            S_TRIM_CHK:
            begin
                if (sts.rd_link_valid)
                begin
                    cmd.trim_step = 1'b1;
                end
                else
                begin
                    cmd.set_status_en = 1'b1;
                    cmd.status_code   = ST_BROKEN;
                end
            end
            S_TAIL_RD:   cmd.rd_cur = 1'b1;
            S_TAIL_CHK:
            begin
                cmd.tail_cut = 1'b1;
                if (!sts.rd_link_valid && !sts.rd_end)
                begin
                    cmd.set_status_en = 1'b1;
                    cmd.status_code   = ST_BROKEN;
                end
            end
            S_REL_RD:    cmd.rd_cur = 1'b1;
            S_REL_CHK:
            begin
                cmd.rel_free = 1'b1;
                priority if (sts.rd_end)
                begin
                    cmd.rel_ok = 1'b1;
                end
                else if (!sts.rd_link_valid)
                begin
                    cmd.set_status_en = 1'b1;
                    cmd.status_code   = ST_BROKEN;
                end
                else
                begin
                    cmd.rel_ok = 1'b0;
                end
            end
            S_DONE:      cmd.out_load = sts.out_free;
            default:     ;
        endcase
    end

    // result register only loaded when it is free or being emptied
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> sts.out_free)
        else $error("result loaded over an unread result");

    // at most one table write source per cycle
    a_one_write: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.clr_step, cmd.grab, cmd.link, cmd.tail_cut, cmd.rel_free}))
        else $error("conflicting link table writes");

    // nothing is taken or delivered during the clearing pass
    a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> (!cmd.load && !cmd.out_load))
        else $error("request handled during clearing pass");

endmodule
